// ===== hdl/packet_size_histogram_unit_macros.svh =====
// Assertion macros for the packet size histogram unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef PACKET_SIZE_HISTOGRAM_UNIT_MACROS_SVH
`define PACKET_SIZE_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PHIST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// Next-cycle implication, disabled during reset.
`define PHIST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

// ===== hdl/phist_pkg.sv =====
// Shared constants, types and helpers for the packet size histogram unit.
// No dependencies.
`timescale 1ns / 1ps

package phist_pkg;

	localparam int LOG_BINS    = 16;
	localparam int MAX_LEN     = 9180;
	localparam int COUNT_WIDTH = 32;

	localparam int LEN_DEPTH   = MAX_LEN + 1;
	localparam int LOG_W       = $clog2(LOG_BINS);
	localparam int ADDR_W      = $clog2(LEN_DEPTH);
	localparam int OPC_W       = 2;
	localparam int SIZE_W      = 16;
	localparam int IDX_W       = 14;
	localparam int OUT_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Opcodes on the input channel
	localparam logic [OPC_W-1:0] OPC_RECORD  = 2'd0;
	localparam logic [OPC_W-1:0] OPC_RD_LOG  = 2'd1;
	localparam logic [OPC_W-1:0] OPC_RD_LEN  = 2'd2;

	// Operations handed from the front to the back
	localparam logic [2:0] BOP_REC     = 3'd0;
	localparam logic [2:0] BOP_REC_LEN = 3'd1;
	localparam logic [2:0] BOP_RD_LOG  = 3'd2;
	localparam logic [2:0] BOP_RD_LEN  = 3'd3;
	localparam logic [2:0] BOP_ZERO    = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [LOG_W-1:0]  bin;
		logic [ADDR_W-1:0] addr;
	} phist_entry_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH+OUT_W-1:0] w;
		w = {{OUT_W{1'b0}}, v};
		return w[OUT_W-1:0];
	endfunction

endpackage

// ===== hdl/phist_fifo.sv =====
// Short queue of classified operations between front and back.
// Depends on phist_pkg.
`timescale 1ns / 1ps

module phist_fifo import phist_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  phist_entry_t push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output phist_entry_t pop_data
);

	phist_entry_t      slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hdl/phist_front.sv =====
// Front end: accepts input beats, finds the log bin, clamps lengths and
// range-checks reads. Holds the exact-mode register. Depends on phist_pkg.
`timescale 1ns / 1ps

module phist_front import phist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [SIZE_W-1:0] pkt_len,
	input  logic [IDX_W-1:0]  bin_index,
	input  logic              clearing,
	input  logic              q_full,
	output logic              q_push,
	output phist_entry_t      q_data
);

	localparam int POS_W = $clog2(SIZE_W);

	logic              exact_q;
	logic [POS_W-1:0]  pos;
	logic [LOG_W-1:0]  rec_bin;
	logic [ADDR_W-1:0] rec_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exact_q <= 1'b0;
		else if (cfg_we)
			exact_q <= cfg_wdata;
	end

	// Highest set bit; sizes 0 and 1 land in bin 0
	always_comb begin
		pos = '0;
		for (int i = 1; i < SIZE_W; i++) begin
			if (pkt_len[i])
				pos = POS_W'(i);
		end
	end

	assign rec_bin = (int'(pos) > LOG_BINS - 1) ? LOG_W'(LOG_BINS - 1) : LOG_W'(pos);
	assign rec_len = (pkt_len > SIZE_W'(MAX_LEN)) ? ADDR_W'(MAX_LEN)
	                                              : pkt_len[ADDR_W-1:0];

	assign in_ready = !q_full && !clearing;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		q_data.op   = BOP_ZERO;
		q_data.bin  = '0;
		q_data.addr = '0;
		case (opcode)
			OPC_RECORD: begin
				q_data.op   = exact_q ? BOP_REC_LEN : BOP_REC;
				q_data.bin  = rec_bin;
				q_data.addr = rec_len;
			end
			OPC_RD_LOG: begin
				if (int'(bin_index) < LOG_BINS) begin
					q_data.op  = BOP_RD_LOG;
					q_data.bin = bin_index[LOG_W-1:0];
				end
			end
			OPC_RD_LEN: begin
				if (int'(bin_index) <= MAX_LEN) begin
					q_data.op   = BOP_RD_LEN;
					q_data.addr = bin_index[ADDR_W-1:0];
				end
			end
			default: begin
				// reserved opcode: zero result, no update
				q_data.op = BOP_ZERO;
			end
		endcase
	end

endmodule

// ===== hdl/phist_back.sv =====
// Back end: log-bin counters in flops, per-length counters in a memory with
// read-modify-write, clearing pass after reset and the output register.
// Depends on phist_pkg.
`timescale 1ns / 1ps

module phist_back import phist_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  phist_entry_t     q_data,
	output logic             q_pop,
	output logic             clearing,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [LOG_W-1:0] log_bin,
	output logic [OUT_W-1:0] count_value
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_RMW   = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	logic [1:0]             state_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [ADDR_W-1:0]      len_addr_q;
	logic                   out_valid_q;
	logic [LOG_W-1:0]       log_bin_q;
	logic [OUT_W-1:0]       count_q;
	logic [COUNT_WIDTH-1:0] log_cnt_q [LOG_BINS];
	logic [COUNT_WIDTH-1:0] len_mem [LEN_DEPTH];
	logic [COUNT_WIDTH-1:0] mem_rdata_q;

	logic                   slot_free;
	logic [COUNT_WIDTH-1:0] log_cur;
	logic [COUNT_WIDTH-1:0] log_new;
	logic                   is_rec;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_waddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;
	logic                   mem_re;

	assign clearing    = (state_q == ST_CLEAR);
	assign out_valid   = out_valid_q;
	assign log_bin     = log_bin_q;
	assign count_value = count_q;

	assign slot_free = !out_valid_q || out_ready;
	assign q_pop     = (state_q == ST_RUN) && q_not_empty && slot_free;
	assign log_cur   = log_cnt_q[q_data.bin];
	assign log_new   = sat_inc(log_cur);
	assign is_rec    = (q_data.op == BOP_REC) || (q_data.op == BOP_REC_LEN);
	assign mem_re    = q_pop && ((q_data.op == BOP_REC_LEN) || (q_data.op == BOP_RD_LEN));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = len_addr_q;
		mem_wdata = sat_inc(mem_rdata_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_RMW: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			len_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			mem_rdata_q <= len_mem[q_data.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LOG_BINS; i++)
				log_cnt_q[i] <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAX_LEN))
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (q_pop && q_data.op == BOP_REC_LEN)
						state_q <= ST_RMW;
					else if (q_pop && q_data.op == BOP_RD_LEN)
						state_q <= ST_READ;
				end
				ST_RMW:  state_q <= ST_RUN;
				ST_READ: state_q <= ST_RUN;
				default: state_q <= ST_CLEAR;
			endcase

			if ((q_pop && q_data.op != BOP_RD_LEN) || state_q == ST_READ)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (q_pop && is_rec)
				log_cnt_q[q_data.bin] <= log_new;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			len_addr_q <= q_data.addr;
			case (q_data.op)
				BOP_REC, BOP_REC_LEN: begin
					log_bin_q <= q_data.bin;
					count_q   <= to_out(log_new);
				end
				BOP_RD_LOG: begin
					log_bin_q <= '0;
					count_q   <= to_out(log_cur);
				end
				default: begin
					log_bin_q <= '0;
					count_q   <= '0;
				end
			endcase
		end else if (state_q == ST_READ) begin
			log_bin_q <= '0;
			count_q   <= to_out(mem_rdata_q);
		end
	end

endmodule

// ===== hdl/packet_size_histogram_unit.sv =====
// Packet size histogram: 16 power-of-two bins plus an optional per-length
// store of 9181 bins, all 32-bit saturating counters.
//
// Input channel (in_valid/in_ready) carries opcode, pkt_len, bin_index:
// record a packet, read a log bin, or read a length bin. Each beat gives
// exactly one output beat (out_valid/out_ready) with log_bin and count_value.
// cfg_we/cfg_wdata set exact mode; write it only while the unit is idle.
// A record (with or without exact mode), a log read or a reserved opcode
// goes to the output register as it leaves the queue; a length read first
// passes the registered read of the per-length memory. A record with exact
// mode and a length read then hold the back end in ST_RMW or ST_READ
// respectively, because of that registered memory read; the rest do not.
// A two-entry queue lets the front keep taking beats while the back works.
// After reset the per-length memory is cleared one entry a cycle, all
// 9181 entries, with in_ready low. When the receiver stalls, the output
// register holds its beat and the queue fills, then in_ready drops.
// Depends on phist_pkg, phist_front, phist_fifo, phist_back.
`timescale 1ns / 1ps

module packet_size_histogram_unit import phist_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OPC_W-1:0]  opcode,
	input  logic [SIZE_W-1:0] pkt_len,
	input  logic [IDX_W-1:0]  bin_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LOG_W-1:0]  log_bin,
	output logic [OUT_W-1:0]  count_value
);

	logic         clearing;
	logic         q_full;
	logic         q_push;
	logic         q_pop;
	logic         q_not_empty;
	phist_entry_t q_in;
	phist_entry_t q_out;

	phist_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.pkt_len    (pkt_len),
		.bin_index  (bin_index),
		.clearing   (clearing),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_in)
	);

	phist_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.pop_data (q_out)
	);

	phist_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.clearing   (clearing),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.log_bin    (log_bin),
		.count_value(count_value)
	);

endmodule

// ===== hdl/phist_checker.sv =====
// Port-level checks for the packet size histogram unit, bound to the top.
// Depends on phist_pkg and packet_size_histogram_unit_macros.svh.
`timescale 1ns / 1ps
`include "packet_size_histogram_unit_macros.svh"

module phist_checker import phist_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OPC_W-1:0]  opcode,
	input logic [SIZE_W-1:0] pkt_len,
	input logic [IDX_W-1:0]  bin_index,
	input logic              out_valid,
	input logic              out_ready,
	input logic [LOG_W-1:0]  log_bin,
	input logic [OUT_W-1:0]  count_value
);

	// hold a stalled output beat
	`PHIST_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(log_bin) && $stable(count_value))

	// sender keeps a stalled input beat
	`PHIST_ASSERT_NXT(a_in_hold, in_valid && !in_ready,
		in_valid && $stable(opcode) && $stable(pkt_len) && $stable(bin_index))

	// a record into a nonzero bin always reports a count of at least one
	`PHIST_ASSERT_IMP(a_rec_count, out_valid && log_bin != '0, count_value != '0)

	// right after reset the length store is being cleared
	`PHIST_ASSERT_IMP(a_clear_after_reset, !$past(arst_n), !in_ready)

endmodule

bind packet_size_histogram_unit phist_checker u_phist_checker (.*);
